[design/tbpf_pkg.sv]
// package: constants, codes and word layouts of the tile background pixel fetcher
`timescale 1ns / 1ps

package tbpf_pkg;

  // screen and store geometry
  localparam int SCREEN_WIDTH = 160;
  localparam int MAP_WIDTH    = 32;
  localparam int STORE_BYTES  = 8192;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int MAP_SHIFT    = $clog2(MAP_WIDTH);

  // signed tile addressing: base plus id with its top bit flipped
  localparam logic [ADDR_W-1:0] SIGNED_TILE_BASE = 13'h0800;
  localparam logic [7:0]        ID_FLIP          = 8'h80;

  // field widths
  localparam int OP_W     = 2;
  localparam int WDATA_W  = 32;
  localparam int COLOR_W  = 32;
  localparam int CIDX_W   = 2;
  localparam int POS_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // packed word widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // operation codes
  localparam logic [OP_W-1:0] OP_VRAM_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_PAL_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RENDER     = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_MAP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAP       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIGNED   = 3'd7;

  // configuration reset values
  localparam logic [ADDR_W-1:0] BG_MAP_RESET  = 13'd6144;
  localparam logic [ADDR_W-1:0] WIN_MAP_RESET = 13'd7168;

endpackage

[design/tbpf_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps

module tbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, or read into the output register; the register holds otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[design/tile_background_pixel_fetcher.sv]
// top level: tiled background and window pixel fetcher
//
// usage
//   in_*  : command words. in_tuser carries the operation (video byte write,
//           palette write, render next pixel, restart frame); in_tdata the
//           store address and write data.
//   out_* : one word per render command, in command order.
//   cfg_* : register writes, always ready; write only while the block is idle.
// sequencing
//   a render word uses the single video ram port for three reads (tile id,
//   then the two tile-row bytes), so no new render is taken until the last
//   of them is issued; the pixel word is registered in the phase after the
//   second byte read. write and restart words do not enter the sequencer.
//   a new command is taken while a finished pixel still waits in the output
//   register; the fetch reads and a pixel that cannot enter it hold the input.
// reset
//   rst_n clears the screen position, the sequencer and the output valid flag
//   and resets the configuration registers. video ram and palette are not cleared.
//   a stalled receiver keeps out_tdata and out_tuser stable.
`timescale 1ns / 1ps

module tile_background_pixel_fetcher (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word: address[12:0], write_data[44:13], zero pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tbpf_pkg::IN_DATA_W-1:0]      in_tdata,
  // input user: operation[1:0]
  input  logic [tbpf_pkg::OP_W-1:0]           in_tuser,
  // output word: pixel_color[31:0], colour_idx[33:32], screen_x[41:34],
  // screen_y[49:42], zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tbpf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // output user: from_window[0]
  output logic                                out_tuser,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import tbpf_pkg::*;

  // sequencer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ID   = 2'd1;
  localparam logic [1:0] PH_B0   = 2'd2;
  localparam logic [1:0] PH_B1   = 2'd3;

  // configuration registers
  logic [POS_W-1:0]  hscroll_r, vscroll_r, win_left_r, window_y_r;
  logic              window_enable_r, tile_signed_r;
  logic [ADDR_W-1:0] bg_map_r, win_map_r;

  // position and sequencer
  logic [POS_W-1:0]  col_r, col_nxt, line_r, line_nxt;
  logic [1:0]        phase_r, phase_nxt;

  // per-pixel context
  logic [POS_W-1:0]  sx_r, sy_r;
  logic [2:0]        px_lo_r, py_lo_r;
  logic              win_r;
  logic [ADDR_W-1:0] row_addr_r;
  logic [7:0]        b0_r;

  // palette in flip-flops
  logic [COLOR_W-1:0] palette_r [4];

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  // ram port
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  // input word fields
  logic [OP_W-1:0]    in_op;
  logic [ADDR_W-1:0]  in_addr;
  logic [WDATA_W-1:0] in_wdata;

  logic accept, acc_render, finish;

  // pixel address arithmetic
  logic              win;
  logic [POS_W-1:0]  px, py;
  logic [ADDR_W-1:0] map_base, map_addr, tile_base, row_addr;
  logic [8:0]        col_inc;
  logic [2:0]        bit_sel;
  logic [CIDX_W-1:0] cidx;

  assign in_op    = in_tuser;
  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_wdata = in_tdata[ADDR_W +: WDATA_W];

  // handshakes
  assign finish     = !out_valid_r || out_tready;
  assign in_tready  = (phase_r == PH_IDLE) || ((phase_r == PH_B1) && finish);
  assign accept     = in_tvalid && in_tready;
  assign acc_render = accept && (in_op == OP_RENDER);
  assign cfg_ready  = 1'b1;

  // window decision and map coordinates for the current position
  always_comb begin
    win = window_enable_r && (line_r >= window_y_r) &&
          (({1'b0, col_r} + 9'd8) >= {1'b0, win_left_r});
    if (win) begin
      px       = col_r;
      py       = line_r - window_y_r;
      map_base = win_map_r;
    end else begin
      px       = col_r + hscroll_r;
      py       = line_r + vscroll_r;
      map_base = bg_map_r;
    end
    map_addr = map_base + {{(ADDR_W - 2 * MAP_SHIFT){1'b0}}, py[7:3], px[7:3]};
  end

  // tile row address from the tile id on the ram output
  always_comb begin
    if (tile_signed_r) begin
      tile_base = SIGNED_TILE_BASE + {1'b0, ram_rdata ^ ID_FLIP, 4'b0000};
    end else begin
      tile_base = {1'b0, ram_rdata, 4'b0000};
    end
    row_addr = tile_base + {{(ADDR_W - 4){1'b0}}, py_lo_r, 1'b0};
  end

  // ram port selection
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = map_addr;
    ram_wdata = in_wdata[7:0];
    case (phase_r)
      PH_ID: begin
        ram_en   = 1'b1;
        ram_addr = row_addr;
      end
      PH_B0: begin
        ram_en   = 1'b1;
        ram_addr = {row_addr_r[ADDR_W-1:1], 1'b1};
      end
      default: begin
        if (accept && (in_op == OP_VRAM_WRITE)) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = in_addr;
        end else if (acc_render) begin
          ram_en   = 1'b1;
        end
      end
    endcase
  end

  tbpf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_vram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // sequencer next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: phase_nxt = acc_render ? PH_ID : PH_IDLE;
      PH_ID:   phase_nxt = PH_B0;
      PH_B0:   phase_nxt = PH_B1;
      PH_B1: begin
        if (finish) begin
          phase_nxt = acc_render ? PH_ID : PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // screen position advance
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    col_inc  = {1'b0, col_r} + 9'd1;
    if (accept && (in_op == OP_RESTART)) begin
      col_nxt  = '0;
      line_nxt = '0;
    end else if (acc_render) begin
      if (col_inc >= 9'(SCREEN_WIDTH)) begin
        col_nxt  = '0;
        line_nxt = line_r + 8'd1;
      end else begin
        col_nxt  = col_inc[POS_W-1:0];
      end
    end
  end

  // colour index: first byte high bit, bit 7 leftmost
  assign bit_sel = ~px_lo_r;
  assign cidx    = {b0_r[bit_sel], ram_rdata[bit_sel]};

  // output register next valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((phase_r == PH_B1) && finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      col_r       <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hscroll_r       <= '0;
      vscroll_r       <= '0;
      win_left_r      <= '0;
      window_y_r      <= '0;
      window_enable_r <= 1'b0;
      bg_map_r        <= BG_MAP_RESET;
      win_map_r       <= WIN_MAP_RESET;
      tile_signed_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCROLL_X:      hscroll_r       <= cfg_data[POS_W-1:0];
        CFG_SCROLL_Y:      vscroll_r       <= cfg_data[POS_W-1:0];
        CFG_WINDOW_X:      win_left_r      <= cfg_data[POS_W-1:0];
        CFG_WINDOW_Y:      window_y_r      <= cfg_data[POS_W-1:0];
        CFG_WINDOW_ENABLE: window_enable_r <= cfg_data[0];
        CFG_BG_MAP:        bg_map_r        <= cfg_data[ADDR_W-1:0];
        CFG_WIN_MAP:       win_map_r       <= cfg_data[ADDR_W-1:0];
        CFG_TILE_SIGNED:   tile_signed_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-pixel context, captured on acceptance and along the fetch
  always_ff @(posedge clk) begin
    if (acc_render) begin
      sx_r    <= col_r;
      sy_r    <= line_r;
      px_lo_r <= px[2:0];
      py_lo_r <= py[2:0];
      win_r   <= win;
    end
    if (phase_r == PH_ID) begin
      row_addr_r <= row_addr;
    end
    if (phase_r == PH_B0) begin
      b0_r <= ram_rdata;
    end
  end

  // palette writes
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_PAL_WRITE)) begin
      palette_r[in_addr[1:0]] <= in_wdata;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if ((phase_r == PH_B1) && finish) begin
      out_data_r <= {6'd0, sy_r, sx_r, cidx, palette_r[cidx]};
      out_user_r <= win_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[dv/tb_tile_background_pixel_fetcher.sv]
// testbench: self-checking stream test of the tile background pixel fetcher
`timescale 1ns / 1ps

module tb_tile_background_pixel_fetcher;
  import tbpf_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int HOLD_AFTER  = 150;    // pixels taken before the long output stall
  localparam int HOLD_CYCLES = 600;
  localparam int FRAME_RENDERS = 2 * SCREEN_WIDTH + 40;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [WDATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CIDX_W-1:0]  cidx;
    logic [POS_W-1:0]   sx;
    logic [POS_W-1:0]   sy;
    logic               win;
  } pixel_t;

  typedef struct packed {
    logic [7:0]        hscroll;
    logic [7:0]        vscroll;
    logic [7:0]        win_x;
    logic [7:0]        win_y;
    logic              win_en;
    logic [ADDR_W-1:0] bg_map;
    logic [ADDR_W-1:0] win_map;
    logic              tile_signed;
  } cfg_t;

  typedef struct packed {
    logic              win;
    logic [7:0]        px;
    logic [7:0]        py;
    logic [ADDR_W-1:0] map_addr;
  } locate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // input word: address[12:0], write_data[44:13], zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // input user: operation[1:0]
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // output word: pixel_color[31:0], colour_idx[33:32], screen_x[41:34], screen_y[49:42]
  logic [OUT_DATA_W-1:0] out_tdata;
  // output user: from_window[0]
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tile_background_pixel_fetcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register view, changed only while the block is idle
  cfg_t view_cfg = '{hscroll: 8'd0, vscroll: 8'd0, win_x: 8'd0, win_y: 8'd0, win_en: 1'b0,
                     bg_map: BG_MAP_RESET, win_map: WIN_MAP_RESET, tile_signed: 1'b0};

  // predicted block state, updated as words are accepted
  logic [7:0]         vram_model [0:STORE_BYTES-1];
  logic [COLOR_W-1:0] pal_model [0:3];
  logic [7:0]         col_model = '0;
  logic [7:0]         line_model = '0;
  pixel_t             pending_pixels [$];

  // planning state: what will be written by the time each word is taken
  logic [7:0]         plan_vram [0:STORE_BYTES-1];
  bit                 plan_written [0:STORE_BYTES-1];
  bit                 plan_pal_written [0:3];
  logic [7:0]         plan_col = '0;
  logic [7:0]         plan_line = '0;
  cmd_t               cmd_backlog [$];

  int cmds_planned = 0;
  int cmds_taken = 0;
  int pixels_checked = 0;
  int window_pixels = 0;
  int line_ends = 0;
  int reg_writes = 0;
  int err_cnt = 0;
  int cycle_count = 0;

  // sender and receiver pacing
  cmd_t cur_cmd;
  int   burst_left = 0;
  int   gap_left = 0;
  int   calm_left = 0;
  int   rx_taken = 0;
  int   rx_mode = 0;
  int   rx_stretch = 0;
  int   rx_tick = 0;
  int   stall_left = 0;
  bit   stall_done = 1'b0;

  // screen position to map entry, window or scrolled background
  function automatic locate_t locate_pixel(logic [7:0] col, logic [7:0] line);
    locate_t r;
    logic [ADDR_W-1:0] base;
    r.win = view_cfg.win_en && (line >= view_cfg.win_y) &&
            (({1'b0, col} + 9'd8) >= {1'b0, view_cfg.win_x});
    if (r.win) begin
      r.px = col;
      r.py = line - view_cfg.win_y;
      base = view_cfg.win_map;
    end else begin
      r.px = col + view_cfg.hscroll;
      r.py = line + view_cfg.vscroll;
      base = view_cfg.bg_map;
    end
    r.map_addr = base + {3'b000, r.py[7:3], r.px[7:3]};
    return r;
  endfunction

  // first byte of the tile row, unsigned or signed id addressing
  function automatic logic [ADDR_W-1:0] row_addr_of(logic [7:0] id, logic [7:0] py);
    logic [ADDR_W-1:0] base;
    if (view_cfg.tile_signed) base = SIGNED_TILE_BASE + {1'b0, id ^ ID_FLIP, 4'b0000};
    else base = {1'b0, id, 4'b0000};
    return base + {9'd0, py[2:0], 1'b0};
  endfunction

  // first byte is the high plane, bit 7 is the leftmost pixel
  function automatic logic [1:0] plane_index(logic [7:0] hi, logic [7:0] lo, logic [7:0] px);
    logic [2:0] bitpos;
    bitpos = 3'd7 - px[2:0];
    return {hi[bitpos], lo[bitpos]};
  endfunction

  // returns {line, column} after one rendered pixel
  function automatic logic [15:0] next_position(logic [7:0] col, logic [7:0] line);
    if (int'(col) + 1 >= SCREEN_WIDTH) return {line + 8'd1, 8'd0};
    return {line, col + 8'd1};
  endfunction

  // expected effect of one accepted command word
  function automatic void apply_to_model(cmd_t c);
    locate_t           loc;
    logic [7:0]        id;
    logic [ADDR_W-1:0] ta;
    logic [ADDR_W-1:0] ta_lo;
    pixel_t            p;
    case (c.op)
      OP_VRAM_WRITE: vram_model[c.addr] = c.data[7:0];
      OP_PAL_WRITE:  pal_model[c.addr[1:0]] = c.data;
      OP_RESTART: begin
        col_model = '0;
        line_model = '0;
      end
      OP_RENDER: begin
        loc = locate_pixel(col_model, line_model);
        id = vram_model[loc.map_addr];
        ta = row_addr_of(id, loc.py);
        ta_lo = ta + 13'd1;
        p.cidx = plane_index(vram_model[ta], vram_model[ta_lo], loc.px);
        p.color = pal_model[p.cidx];
        p.sx = col_model;
        p.sy = line_model;
        p.win = loc.win;
        pending_pixels.push_back(p);
        if (loc.win) window_pixels++;
        {line_model, col_model} = next_position(col_model, line_model);
        if (col_model == 8'd0) line_ends++;
      end
      default: ;
    endcase
  endfunction

  // queue one command word and track what it leaves written
  function automatic void plan_cmd(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [WDATA_W-1:0] data);
    cmd_t c;
    c.op = op;
    c.addr = addr;
    c.data = data;
    cmd_backlog.push_back(c);
    cmds_planned++;
    case (op)
      OP_VRAM_WRITE: begin
        plan_vram[addr] = data[7:0];
        plan_written[addr] = 1'b1;
      end
      OP_PAL_WRITE: plan_pal_written[addr[1:0]] = 1'b1;
      OP_RESTART: begin
        plan_col = '0;
        plan_line = '0;
      end
      OP_RENDER: {plan_line, plan_col} = next_position(plan_col, plan_line);
      default: ;
    endcase
  endfunction

  // a render, preceded by writes of whatever it would read unwritten
  function automatic void plan_render();
    locate_t           loc;
    logic [ADDR_W-1:0] ta;
    logic [ADDR_W-1:0] ta_lo;
    logic [1:0]        idx;
    loc = locate_pixel(plan_col, plan_line);
    if (!plan_written[loc.map_addr]) plan_cmd(OP_VRAM_WRITE, loc.map_addr, $urandom());
    ta = row_addr_of(plan_vram[loc.map_addr], loc.py);
    ta_lo = ta + 13'd1;
    if (!plan_written[ta]) plan_cmd(OP_VRAM_WRITE, ta, $urandom());
    if (!plan_written[ta_lo]) plan_cmd(OP_VRAM_WRITE, ta_lo, $urandom());
    idx = plane_index(plan_vram[ta], plan_vram[ta_lo], loc.px);
    if (!plan_pal_written[idx])
      plan_cmd(OP_PAL_WRITE, {11'($urandom()), idx}, $urandom());
    plan_cmd(OP_RENDER, 13'($urandom()), $urandom());
  endfunction

  // random mix: mostly renders and runs of renders, writes mostly aimed at live regions
  function automatic void plan_mix(int n);
    int                r;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        plan_render();
      end else if (r < 55) begin
        repeat ($urandom_range(4, 40)) plan_render();
      end else if (r < 78) begin
        case ($urandom_range(0, 2))
          0: a = 13'($urandom());
          1: a = ($urandom_range(0, 1) ? view_cfg.bg_map : view_cfg.win_map) +
                 13'($urandom_range(0, 1023));
          default: a = view_cfg.tile_signed ? SIGNED_TILE_BASE + 13'($urandom_range(0, 4095))
                                            : 13'($urandom_range(0, 4095));
        endcase
        plan_cmd(OP_VRAM_WRITE, a, $urandom());
      end else if (r < 92) begin
        plan_cmd(OP_PAL_WRITE, 13'($urandom()), $urandom());
      end else if (r < 97) begin
        plan_cmd(OP_RESTART, 13'($urandom()), $urandom());
      end else begin
        // restart straight into a render
        plan_cmd(OP_RESTART, 13'($urandom()), $urandom());
        plan_render();
      end
    end
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.hscroll = 8'($urandom());
    c.vscroll = 8'($urandom());
    c.win_x = 8'($urandom());
    c.win_y = 8'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40));
    c.win_en = 1'($urandom());
    c.bg_map = 13'($urandom());
    c.win_map = 13'($urandom());
    c.tile_signed = 1'($urandom());
    return c;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // one register write; valid is left high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_SCROLL_X:      view_cfg.hscroll = val[7:0];
      CFG_SCROLL_Y:      view_cfg.vscroll = val[7:0];
      CFG_WINDOW_X:      view_cfg.win_x = val[7:0];
      CFG_WINDOW_Y:      view_cfg.win_y = val[7:0];
      CFG_WINDOW_ENABLE: view_cfg.win_en = val[0];
      CFG_BG_MAP:        view_cfg.bg_map = val;
      CFG_WIN_MAP:       view_cfg.win_map = val;
      CFG_TILE_SIGNED:   view_cfg.tile_signed = val[0];
      default: ;
    endcase
  endtask

  // all eight registers; unused upper data bits carry noise
  task automatic set_config(cfg_t c);
    cfg_write(CFG_SCROLL_X, {5'($urandom()), c.hscroll});
    cfg_write(CFG_SCROLL_Y, {5'($urandom()), c.vscroll});
    cfg_write(CFG_WINDOW_X, {5'($urandom()), c.win_x});
    cfg_write(CFG_WINDOW_Y, {5'($urandom()), c.win_y});
    cfg_write(CFG_WINDOW_ENABLE, {12'($urandom()), c.win_en});
    cfg_write(CFG_BG_MAP, c.bg_map);
    cfg_write(CFG_WIN_MAP, c.win_map);
    cfg_write(CFG_TILE_SIGNED, {12'($urandom()), c.tile_signed});
    cfg_valid <= 1'b0;
  endtask

  // every planned word taken and every pixel seen, then let writes settle
  task automatic wait_idle();
    while (cmds_taken != cmds_planned || pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // command driver: bursts with random gaps, stretches with none
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_to_model(cur_cmd);
        cmds_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b000, cur_cmd.data, cur_cmd.addr};
          in_tuser <= cur_cmd.op;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if (calm_left != 0) begin
              calm_left--;
              gap_left = 0;
            end else if ($urandom_range(0, 29) == 0) begin
              calm_left = 40;
              gap_left = 0;
            end else if ($urandom_range(0, 9) == 0) begin
              gap_left = $urandom_range(10, 30);
            end else begin
              gap_left = $urandom_range(0, 5);
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver: changing stall modes plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_taken++;
      rx_tick++;
      if (!stall_done && rx_taken >= HOLD_AFTER) begin
        stall_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        if (rx_stretch != 0) begin
          rx_stretch--;
        end else begin
          rx_mode = $urandom_range(0, 3);
          rx_stretch = $urandom_range(16, 256);
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((rx_tick % 7) > 1);
        endcase
      end
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word 0x%0h", out_tdata);
        err_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_color", want.color, out_tdata[31:0]);
        check_field("colour_idx", 32'(want.cidx), 32'(out_tdata[33:32]));
        check_field("screen_x", 32'(want.sx), 32'(out_tdata[41:34]));
        check_field("screen_y", 32'(want.sy), 32'(out_tdata[49:42]));
        check_field("from_window", 32'(want.win), 32'(out_tuser));
        pixels_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    cfg_t c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: palette and store extremes, one known tile row, restarts
    plan_cmd(OP_PAL_WRITE, 13'h1FFF, 32'hFFFF_FFFF);
    plan_cmd(OP_PAL_WRITE, 13'h0000, 32'h0000_0000);
    plan_cmd(OP_PAL_WRITE, 13'h1FFD, 32'h8000_0001);
    plan_cmd(OP_PAL_WRITE, 13'h0AAA, 32'h7FFF_FFFE);
    plan_cmd(OP_VRAM_WRITE, 13'h1FFF, 32'hFFFF_FFFF);
    plan_cmd(OP_VRAM_WRITE, 13'h0000, 32'h0000_0000);
    plan_cmd(OP_VRAM_WRITE, BG_MAP_RESET, 32'h0000_00FF);
    plan_cmd(OP_VRAM_WRITE, 13'd4080, 32'hFFFF_FFAA);
    plan_cmd(OP_VRAM_WRITE, 13'd4081, 32'h0000_0055);
    repeat (9) plan_render();
    plan_cmd(OP_RESTART, 13'h1FFF, 32'hFFFF_FFFF);
    plan_render();
    plan_cmd(OP_VRAM_WRITE, BG_MAP_RESET, 32'h0000_0000);
    plan_cmd(OP_RESTART, 13'h0000, 32'h0000_0000);
    plan_render();
    plan_mix(40);
    wait_idle();

    // full scroll, background map at the top of the store, signed ids
    c = '{hscroll: 8'hFF, vscroll: 8'hFF, win_x: 8'h00, win_y: 8'h00, win_en: 1'b0,
          bg_map: 13'h1FFF, win_map: 13'h0000, tile_signed: 1'b1};
    set_config(c);
    plan_mix(40);
    wait_idle();

    // window over everything from a zero left edge, its map wrapping
    c = '{hscroll: 8'($urandom()), vscroll: 8'($urandom()), win_x: 8'h00, win_y: 8'h00,
          win_en: 1'b1, bg_map: 13'h0000, win_map: 13'h1FFF, tile_signed: 1'b0};
    set_config(c);
    plan_mix(40);
    wait_idle();

    // window edge beyond the screen, window line at the bottom
    c = '{hscroll: 8'h00, vscroll: 8'h00, win_x: 8'hFF, win_y: 8'hFF, win_en: 1'b1,
          bg_map: 13'd4000, win_map: 13'h0000, tile_signed: 1'b1};
    set_config(c);
    plan_mix(40);
    wait_idle();

    repeat (3) begin
      set_config(random_cfg());
      if ($urandom_range(0, 1)) plan_cmd(OP_RESTART, 13'($urandom()), $urandom());
      plan_mix(40);
      wait_idle();
    end

    // more than two lines in a row, so the column wraps under a partial window
    c = random_cfg();
    c.win_en = 1'b1;
    c.win_x = 8'($urandom_range(8, SCREEN_WIDTH + 7));
    c.win_y = 8'($urandom_range(1, 2));
    set_config(c);
    plan_cmd(OP_RESTART, 13'($urandom()), $urandom());
    repeat (FRAME_RENDERS) plan_render();
    wait_idle();

    $display("%0d command words, %0d register writes, %0d pixels checked (%0d from the window)",
             cmds_taken, reg_writes, pixels_checked, window_pixels);
    $display("%0d line end(s) crossed; long output hold-off applied: %0d",
             line_ends, stall_done);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/tbpf_pkg.sv
design/tbpf_ram.sv
design/tile_background_pixel_fetcher.sv
dv/tb_tile_background_pixel_fetcher.sv
